[design/prfd_pkg.sv]
// ----------------------------------------------------------------------------
// prfd_pkg: shared types and constants for the route forward decision block
// Payload structs, opcodes, verdict codes, control/status bundles, mask helper.
// ----------------------------------------------------------------------------
package prfd_pkg;

   localparam int DEF_ROUTE_ENTRIES    = 128;
   localparam int DEF_OWNED_ENTRIES    = 16;
   localparam int DEF_PORTS            = 16;
   localparam int DEF_NEIGHBOR_ID_BITS = 4;

   localparam logic [31:0] FULL_MASK = 32'hFFFF_FFFF;
   localparam logic [5:0]  MAX_PLEN  = 6'd32;

   localparam int CSR_DATA_BITS = 8;

   typedef enum logic [1:0] {
      OP_OWNED_WR = 2'd0,
      OP_ROUTE_WR = 2'd1,
      OP_NBR_WR   = 2'd2,
      OP_LOOKUP   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      VERDICT_DONE        = 3'd0,
      VERDICT_LOCAL       = 3'd1,
      VERDICT_FORWARD     = 3'd2,
      VERDICT_NO_NEIGHBOR = 3'd3,
      VERDICT_NO_ROUTE    = 3'd4
   } verdict_type;

   typedef enum logic {
      CSR_OWNED_COUNT = 1'b0,
      CSR_ROUTE_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  entry_index;
      logic [31:0] address;
      logic [5:0]  prefix_length;
      logic [3:0]  port_number;
      logic [3:0]  neighbor_id;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [3:0]  out_port;
      logic [3:0]  next_hop;
   } rsp_type;

   typedef struct packed {
      logic [31:0] network;
      logic [5:0]  plen;
   } owned_entry_type;

   typedef struct packed {
      logic [31:0] network;
      logic [5:0]  plen;
      logic [3:0]  port;
   } route_entry_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      logic        cnt_clr;
      logic        cnt_inc;
      logic        wr;
      logic        emit;
      verdict_type verdict;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic own_end;
      logic own_hit;
      logic rt_end;
      logic rt_hit;
      logic nbr_ok;
   } dp_status_type;

   // prefix 0 gives no bits, anything above 32 is an exact match
   function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
      logic [5:0] len_c;
      len_c = (plen > MAX_PLEN) ? MAX_PLEN : plen;
      return ~(FULL_MASK >> len_c);
   endfunction

endpackage

[design/prfd_ctrl.sv]
// ----------------------------------------------------------------------------
// prfd_ctrl: sequencing for writes and lookups
// Walks owned entries, then routes, then the neighbor map, with a read state and a compare state per entry.
// ----------------------------------------------------------------------------
module prfd_ctrl
   import prfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    opcode,
   input  dp_status_type status,
   output logic          busy,
   output ctl_cmd_type   cmd
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_WRITE   = 7'b0000010,
      S_OWN_RD  = 7'b0000100,
      S_OWN_CMP = 7'b0001000,
      S_RT_RD   = 7'b0010000,
      S_RT_CMP  = 7'b0100000,
      S_NBR_CMP = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.verdict = VERDICT_DONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load    = 1'b1;
               cmd.cnt_clr = 1'b1;
               state_in    = (opcode == OP_LOOKUP) ? S_OWN_RD : S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.wr      = 1'b1;
            cmd.emit    = 1'b1;
            cmd.verdict = VERDICT_DONE;
            state_in    = S_IDLE;
         end
         S_OWN_RD: begin
            if (status.own_end) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_RT_RD;
            end else begin
               state_in = S_OWN_CMP;
            end
         end
         S_OWN_CMP: begin
            if (status.own_hit) begin
               cmd.emit    = 1'b1;
               cmd.verdict = VERDICT_LOCAL;
               state_in    = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_OWN_RD;
            end
         end
         S_RT_RD: begin
            if (status.rt_end) begin
               cmd.emit    = 1'b1;
               cmd.verdict = VERDICT_NO_ROUTE;
               state_in    = S_IDLE;
            end else begin
               state_in = S_RT_CMP;
            end
         end
         S_RT_CMP: begin
            if (status.rt_hit) begin
               state_in = S_NBR_CMP;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_RT_RD;
            end
         end
         S_NBR_CMP: begin
            cmd.emit    = 1'b1;
            cmd.verdict = status.nbr_ok ? VERDICT_FORWARD : VERDICT_NO_NEIGHBOR;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[design/prfd_datapath.sv]
// ----------------------------------------------------------------------------
// prfd_datapath: tables, scan counter, prefix compare and result register
// Owned, route and neighbor tables each have one write port and one registered read port.
// ----------------------------------------------------------------------------
module prfd_datapath
   import prfd_pkg::*;
#(
   parameter int ROUTE_ENTRIES    = DEF_ROUTE_ENTRIES,
   parameter int OWNED_ENTRIES    = DEF_OWNED_ENTRIES,
   parameter int PORTS            = DEF_PORTS,
   parameter int NEIGHBOR_ID_BITS = DEF_NEIGHBOR_ID_BITS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  req_type                  req_data,
   input  ctl_cmd_type              cmd,
   output dp_status_type            status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data
);

   localparam int OWN_IDX_BITS  = (OWNED_ENTRIES > 1) ? $clog2(OWNED_ENTRIES) : 1;
   localparam int RT_IDX_BITS   = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int PORT_IDX_BITS = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int MAX_ENTRIES   = (OWNED_ENTRIES > ROUTE_ENTRIES) ? OWNED_ENTRIES
                                                                  : ROUTE_ENTRIES;
   localparam int CNT_BITS      = $clog2(MAX_ENTRIES + 1);

   owned_entry_type             own_mem [OWNED_ENTRIES];
   route_entry_type             rt_mem  [ROUTE_ENTRIES];
   logic [NEIGHBOR_ID_BITS-1:0] nbr_mem [PORTS];

   req_type                     req_ff;
   logic [4:0]                  owned_count_ff;
   logic [7:0]                  route_count_ff;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [PORTS-1:0]            has_nbr_ff;
   owned_entry_type             own_rd_ff;
   route_entry_type             rt_rd_ff;
   logic [NEIGHBOR_ID_BITS-1:0] nbr_rd_ff;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_data_ff, rsp_data_in;

   logic [CNT_BITS-1:0]         own_limit, rt_limit;
   logic                        own_we, rt_we, nbr_we;
   logic [OWN_IDX_BITS-1:0]     own_waddr, own_raddr;
   logic [RT_IDX_BITS-1:0]      rt_waddr, rt_raddr;
   logic [PORT_IDX_BITS-1:0]    nbr_waddr, nbr_raddr;
   logic                        port_ok;
   logic                        is_route;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         owned_count_ff <= '0;
         route_count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OWNED_COUNT: owned_count_ff <= csr_data[4:0];
            CSR_ROUTE_COUNT: route_count_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // shared scan counter for owned and route walks
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign own_limit = (owned_count_ff > OWNED_ENTRIES) ? CNT_BITS'(OWNED_ENTRIES)
                                                       : CNT_BITS'(owned_count_ff);
   assign rt_limit  = (route_count_ff > ROUTE_ENTRIES) ? CNT_BITS'(ROUTE_ENTRIES)
                                                       : CNT_BITS'(route_count_ff);

   assign own_we = cmd.wr && (req_ff.opcode == OP_OWNED_WR)
                   && (req_ff.entry_index < OWNED_ENTRIES);
   assign rt_we  = cmd.wr && (req_ff.opcode == OP_ROUTE_WR)
                   && (req_ff.entry_index < ROUTE_ENTRIES);
   assign nbr_we = cmd.wr && (req_ff.opcode == OP_NBR_WR)
                   && (req_ff.port_number < PORTS);

   assign own_waddr = OWN_IDX_BITS'(req_ff.entry_index);
   assign rt_waddr  = RT_IDX_BITS'(req_ff.entry_index);
   assign nbr_waddr = PORT_IDX_BITS'(req_ff.port_number);
   assign own_raddr = cnt_ff[OWN_IDX_BITS-1:0];
   assign rt_raddr  = cnt_ff[RT_IDX_BITS-1:0];
   assign nbr_raddr = PORT_IDX_BITS'(rt_rd_ff.port);

   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[own_waddr] <= '{network: req_ff.address, plen: req_ff.prefix_length};
      end
      own_rd_ff <= own_mem[own_raddr];
   end

   always_ff @(posedge clock) begin
      if (rt_we) begin
         rt_mem[rt_waddr] <= '{network: req_ff.address, plen: req_ff.prefix_length,
                               port: req_ff.port_number};
      end
      rt_rd_ff <= rt_mem[rt_raddr];
   end

   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem[nbr_waddr] <= NEIGHBOR_ID_BITS'(req_ff.neighbor_id);
      end
      nbr_rd_ff <= nbr_mem[nbr_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_nbr_ff <= '0;
      end else if (nbr_we) begin
         has_nbr_ff[nbr_waddr] <= 1'b1;
      end
   end

   assign port_ok = (rt_rd_ff.port < PORTS);

   always_comb begin
      status.own_end = (cnt_ff >= own_limit);
      status.rt_end  = (cnt_ff >= rt_limit);
      status.own_hit = ((req_ff.address ^ own_rd_ff.network)
                        & prefix_mask(own_rd_ff.plen)) == '0;
      status.rt_hit  = ((req_ff.address ^ rt_rd_ff.network)
                        & prefix_mask(rt_rd_ff.plen)) == '0;
      status.nbr_ok  = port_ok && has_nbr_ff[nbr_raddr];
   end

   // route port is reported for forward and no-neighbor verdicts only
   always_comb begin
      is_route             = (cmd.verdict == VERDICT_FORWARD)
                             || (cmd.verdict == VERDICT_NO_NEIGHBOR);
      rsp_data_in.verdict  = cmd.verdict;
      rsp_data_in.out_port = is_route ? rt_rd_ff.port : 4'd0;
      rsp_data_in.next_hop = (cmd.verdict == VERDICT_FORWARD) ? 4'(nbr_rd_ff) : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/prefix_route_forward_decision.sv]
// A table write goes from idle to the write state, which emits the registered result word.
// A lookup ends with a local verdict on an owned hit, otherwise after the route search
// and, on a route hit, the neighbor check; one read, one compare per entry.
// One word in flight; start is taken again once busy drops.
// Reset (synchronous, active high) clears counts, neighbor valid bits and control.
// The result strobe is one cycle wide and cannot be held off.
// ----------------------------------------------------------------------------
// prefix_route_forward_decision: IPv4 first-match route lookup top level
// Owned subnet check, ordered route search and per-port neighbor resolve.
// ----------------------------------------------------------------------------
module prefix_route_forward_decision
   import prfd_pkg::*;
#(
   parameter int ROUTE_ENTRIES    = DEF_ROUTE_ENTRIES,
   parameter int OWNED_ENTRIES    = DEF_OWNED_ENTRIES,
   parameter int PORTS            = DEF_PORTS,
   parameter int NEIGHBOR_ID_BITS = DEF_NEIGHBOR_ID_BITS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   prfd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   prfd_datapath #(
      .ROUTE_ENTRIES    (ROUTE_ENTRIES),
      .OWNED_ENTRIES    (OWNED_ENTRIES),
      .PORTS            (PORTS),
      .NEIGHBOR_ID_BITS (NEIGHBOR_ID_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[design/prfd_checker.sv]
// ----------------------------------------------------------------------------
// prfd_checker: port-level checks for the route forward decision block
// Strobe spacing, busy after start, results after work, and zeroed result fields by verdict.
// ----------------------------------------------------------------------------
module prfd_checker
   import prfd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an accepted word keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted word");

   // every result follows a cycle of work
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in progress");

   // one word in flight, so strobes never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back result strobes");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.verdict != VERDICT_FORWARD) |-> rsp_data.next_hop == 4'd0)
      else $error("next hop set without forward verdict");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.verdict == VERDICT_DONE || rsp_data.verdict == VERDICT_LOCAL
                    || rsp_data.verdict == VERDICT_NO_ROUTE) |-> rsp_data.out_port == 4'd0)
      else $error("out port set without matching route");

endmodule

bind prefix_route_forward_decision prfd_checker u_prfd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
